FILE: rtl/owtsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtsm_pkg
// Shared types, codes and the sequence program of the one-wire master.
// ----------------------------------------------------------------------------
package owtsm_pkg;

	typedef struct packed {
		logic [1:0]  action;
		logic        bus_level;
		logic [63:0] target_rom_id;
	} in_t;

	typedef struct packed {
		logic        bus_pull_low;
		logic        busy_res;
		logic        done_res;
		logic        no_device;
		logic [63:0] rom_id;
		logic        temp_negative;
		logic [15:0] temp_magnitude;
	} out_t;

	typedef struct packed {
		logic pull;
		logic busy;
		logic done;
		logic no_device;
	} seq_status_t;

	typedef enum logic [2:0] {
		KIND_IDLE,
		KIND_RESET,
		KIND_WR_CONST,
		KIND_WR_ID,
		KIND_WAIT,
		KIND_RD_ID,
		KIND_RD_TEMP
	} step_kind_t;

	typedef struct packed {
		step_kind_t  kind;
		logic [7:0]  arg;
		logic [3:0]  next;
	} step_desc_t;

	localparam logic [1:0]  ACT_ROM          = 2'd1;
	localparam logic [1:0]  ACT_TEMP         = 2'd2;

	localparam logic [3:0]  STEP_IDLE        = 4'd0;
	localparam logic [3:0]  STEP_ROM_START   = 4'd1;
	localparam logic [3:0]  STEP_TEMP_START  = 4'd5;

	localparam logic [7:0]  CMD_READ_ROM     = 8'h33;
	localparam logic [7:0]  CMD_MATCH_ROM    = 8'h55;
	localparam logic [7:0]  CMD_CONVERT      = 8'h44;
	localparam logic [7:0]  CMD_READ_PAD     = 8'hBE;

	localparam logic [19:0] WAIT_RESET_VALUE = 20'd800000;

	// Bus timing in microsecond ticks.
	localparam logic [19:0] RST_LOW_END      = 20'd480;
	localparam logic [19:0] RST_POLL_TICK    = 20'd560;
	localparam logic [19:0] RST_PRESENCE_TK  = 20'd561;
	localparam logic [19:0] RST_END          = 20'd960;
	localparam logic [5:0]  PRESENCE_LIMIT   = 6'd60;
	localparam logic [19:0] WR_LOW_END       = 20'd15;
	localparam logic [19:0] WR_SLOT_LAST     = 20'd74;
	localparam logic [19:0] RD_LOW_END       = 20'd4;
	localparam logic [19:0] RD_SAMPLE_TICK   = 20'd14;
	localparam logic [19:0] RD_SLOT_LAST     = 20'd58;

	localparam logic [15:0] NEG_MASK         = 16'hF800;

	function automatic step_desc_t prog_entry(input logic [3:0] s);
		step_desc_t d;
		d = '{KIND_IDLE, 8'd0, STEP_IDLE};
		case (s)
			4'd1:  d = '{KIND_RESET,    8'd0,          4'd2};
			4'd2:  d = '{KIND_WR_CONST, CMD_READ_ROM,  4'd3};
			4'd3:  d = '{KIND_WAIT,     8'd0,          4'd4};
			4'd4:  d = '{KIND_RD_ID,    8'd8,          STEP_IDLE};
			4'd5:  d = '{KIND_RESET,    8'd0,          4'd6};
			4'd6:  d = '{KIND_WR_CONST, CMD_MATCH_ROM, 4'd7};
			4'd7:  d = '{KIND_WR_ID,    8'd0,          4'd8};
			4'd8:  d = '{KIND_WR_CONST, CMD_CONVERT,   4'd9};
			4'd9:  d = '{KIND_WAIT,     8'd0,          4'd10};
			4'd10: d = '{KIND_RESET,    8'd0,          4'd11};
			4'd11: d = '{KIND_WR_CONST, CMD_MATCH_ROM, 4'd12};
			4'd12: d = '{KIND_WR_ID,    8'd0,          4'd13};
			4'd13: d = '{KIND_WR_CONST, CMD_READ_PAD,  4'd14};
			4'd14: d = '{KIND_RD_TEMP,  8'd2,          STEP_IDLE};
			default: d = '{KIND_IDLE,   8'd0,          STEP_IDLE};
		endcase
		return d;
	endfunction

	// A wait step with a zero wait length is skipped on entry.
	function automatic logic [3:0] resolve_step(input logic [3:0] s,
			input logic [19:0] wait_len);
		step_desc_t d;
		d = prog_entry(s);
		if (d.kind == KIND_WAIT && wait_len == 20'd0) begin
			return d.next;
		end
		return s;
	endfunction

endpackage

FILE: rtl/owtsm_temp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtsm_temp
// Turns the raw scratchpad temperature into sign and magnitude.
// ----------------------------------------------------------------------------
module owtsm_temp import owtsm_pkg::*; (
	input  logic [15:0] raw,
	output logic        negative,
	output logic [15:0] magnitude
);

	// Negate only when the five sign-extension bits are all set.
	always_comb begin
		negative  = ((raw & NEG_MASK) == NEG_MASK);
		magnitude = negative ? (~raw + 16'd1) : raw;
	end

endmodule

FILE: rtl/owtsm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtsm_seq
// Sequencer state and the per-tick step logic of the one-wire master.
// ----------------------------------------------------------------------------
module owtsm_seq import owtsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  in_t         tick,
	input  logic [19:0] wait_len,
	output seq_status_t status,
	output logic [63:0] id_next,
	output logic [15:0] raw_next
);

	logic [3:0]  step_q, step_n;
	logic [19:0] tick_q, tick_n;
	logic [5:0]  pres_q, pres_n;
	logic [2:0]  bit_q, bit_n;
	logic [3:0]  byte_q, byte_n;
	logic [7:0]  sh_q, sh_n;
	logic [63:0] id_q, id_n;
	logic [15:0] raw_q, raw_n;
	logic [63:0] send_q, send_n;

	logic        launch;
	logic [3:0]  cur_step;
	logic [19:0] cur_tick;
	logic [5:0]  cur_pres;
	logic [2:0]  cur_bit;
	logic [3:0]  cur_byte;
	logic [7:0]  cur_sh;
	logic [63:0] send_cur;
	step_desc_t  cur_desc;
	logic [7:0]  wr_byte;
	logic        wr_bit;
	logic        seq_done;
	logic        seq_nodev;

	// Launch: an idle sequencer takes a start action and enters the first step.
	always_comb begin
		launch   = (prog_entry(step_q).kind == KIND_IDLE) &&
		           (tick.action == ACT_ROM || tick.action == ACT_TEMP);
		cur_step = step_q;
		cur_tick = tick_q;
		cur_pres = pres_q;
		cur_bit  = bit_q;
		cur_byte = byte_q;
		cur_sh   = sh_q;
		if (prog_entry(step_q).kind == KIND_IDLE) begin
			cur_step = STEP_IDLE;
			if (launch) begin
				cur_step = resolve_step((tick.action == ACT_ROM) ? STEP_ROM_START
				                                                 : STEP_TEMP_START,
				                        wait_len);
				cur_tick = '0;
				cur_pres = '0;
				cur_bit  = '0;
				cur_byte = '0;
				cur_sh   = '0;
			end
		end
		send_cur = launch ? tick.target_rom_id : send_q;
		cur_desc = prog_entry(cur_step);
		wr_byte  = (cur_desc.kind == KIND_WR_CONST) ? cur_desc.arg
		                                            : send_cur[8*cur_byte[2:0] +: 8];
		wr_bit   = wr_byte[cur_bit];
	end

	// Bus drive and busy for this tick.
	always_comb begin
		status.pull      = 1'b0;
		status.busy      = (cur_desc.kind != KIND_IDLE);
		status.done      = seq_done;
		status.no_device = seq_nodev;
		case (cur_desc.kind)
			KIND_RESET:                status.pull = (cur_tick < RST_LOW_END);
			KIND_WR_CONST, KIND_WR_ID: status.pull = (cur_tick < WR_LOW_END) || !wr_bit;
			KIND_RD_ID, KIND_RD_TEMP:  status.pull = (cur_tick < RD_LOW_END);
			default:                   status.pull = 1'b0;
		endcase
	end

	// Next state.
	always_comb begin
		logic       enter;
		logic [3:0] enter_to;
		logic [5:0] pres_inc;
		enter        = 1'b0;
		enter_to     = STEP_IDLE;
		pres_inc     = cur_pres + 6'd1;
		seq_done  = 1'b0;
		seq_nodev = 1'b0;
		step_n = cur_step;
		tick_n = cur_tick;
		pres_n = cur_pres;
		bit_n  = cur_bit;
		byte_n = cur_byte;
		sh_n   = cur_sh;
		id_n   = id_q;
		raw_n  = raw_q;
		send_n = send_cur;

		case (cur_desc.kind)
			KIND_RESET: begin
				if (cur_tick < RST_POLL_TICK) begin
					tick_n = cur_tick + 20'd1;
				end else if (cur_tick == RST_POLL_TICK) begin
					if (!tick.bus_level) begin
						tick_n = RST_PRESENCE_TK;
					end else begin
						pres_n = pres_inc;
						if (pres_inc > PRESENCE_LIMIT) begin
							seq_nodev = 1'b1;
							enter     = 1'b1;
						end
					end
				end else if (cur_tick >= RST_END) begin
					enter    = 1'b1;
					enter_to = cur_desc.next;
				end else begin
					tick_n = cur_tick + 20'd1;
				end
			end
			KIND_WR_CONST, KIND_WR_ID: begin
				if (cur_tick >= WR_SLOT_LAST) begin
					tick_n = '0;
					if (cur_bit == 3'd7) begin
						bit_n = '0;
						if (cur_desc.kind == KIND_WR_CONST) begin
							enter    = 1'b1;
							enter_to = cur_desc.next;
						end else begin
							byte_n = cur_byte + 4'd1;
							if (byte_n >= 4'd8) begin
								enter    = 1'b1;
								enter_to = cur_desc.next;
							end
						end
					end else begin
						bit_n = cur_bit + 3'd1;
					end
				end else begin
					tick_n = cur_tick + 20'd1;
				end
			end
			KIND_WAIT: begin
				if ({1'b0, cur_tick} + 21'd1 >= {1'b0, wait_len}) begin
					enter    = 1'b1;
					enter_to = cur_desc.next;
				end else begin
					tick_n = cur_tick + 20'd1;
				end
			end
			KIND_RD_ID, KIND_RD_TEMP: begin
				if (cur_tick == RD_SAMPLE_TICK) begin
					sh_n = {tick.bus_level, cur_sh[7:1]};
				end
				if (cur_tick >= RD_SLOT_LAST) begin
					tick_n = '0;
					if (cur_bit == 3'd7) begin
						if (cur_desc.kind == KIND_RD_ID) begin
							id_n[8*cur_byte[2:0] +: 8] = cur_sh;
						end else if (cur_byte[2:0] == 3'd0) begin
							raw_n[7:0] = cur_sh;
						end else begin
							raw_n[15:8] = cur_sh;
						end
						bit_n  = '0;
						sh_n   = '0;
						byte_n = cur_byte + 4'd1;
						if ({4'd0, byte_n} >= cur_desc.arg) begin
							seq_done = 1'b1;
							enter    = 1'b1;
						end
					end else begin
						bit_n = cur_bit + 3'd1;
					end
				end else begin
					tick_n = cur_tick + 20'd1;
				end
			end
			default: begin
				step_n = STEP_IDLE;
			end
		endcase

		if (enter) begin
			step_n = resolve_step(enter_to, wait_len);
			tick_n = '0;
			pres_n = '0;
			bit_n  = '0;
			byte_n = '0;
			sh_n   = '0;
		end
	end

	assign id_next  = id_n;
	assign raw_next = raw_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
			tick_q <= '0;
			pres_q <= '0;
			bit_q  <= '0;
			byte_q <= '0;
			sh_q   <= '0;
			id_q   <= '0;
			raw_q  <= '0;
			send_q <= '0;
		end else if (step_en) begin
			step_q <= step_n;
			tick_q <= tick_n;
			pres_q <= pres_n;
			bit_q  <= bit_n;
			byte_q <= byte_n;
			sh_q   <= sh_n;
			id_q   <= id_n;
			raw_q  <= raw_n;
			send_q <= send_n;
		end
	end

endmodule

FILE: rtl/one_wire_temperature_sensor_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_temperature_sensor_master
// One-wire bus master that reads a device ID or a temperature, one tick per
// request.
// ----------------------------------------------------------------------------
// Each input request is one microsecond of bus time: it carries the sampled
// bus level and an optional start action, and produces exactly one result
// request with the bus drive for that tick, busy/done/no-device flags, the
// last ID read and the last temperature as sign and magnitude in 1/16 degree.
// The block takes one request per clock cycle unless the output stalls. The
// result appears in the cycle after acceptance, set by the single sequencer
// step between the state registers and the result register, which decouples
// the two sides, so a new request is taken while the previous result is being
// taken in the same cycle. Write cfg_data (conversion wait in ticks, reset
// value 800000, zero skips the wait) only while no sequence runs.
// ----------------------------------------------------------------------------
module one_wire_temperature_sensor_master import owtsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [19:0] cfg_data
);

	logic [19:0]  wait_len_q;
	logic         in_fire;
	seq_status_t  status;
	logic [63:0]  id_next;
	logic [15:0]  raw_next;
	logic         temp_neg;
	logic [15:0]  temp_mag;
	out_t         res_s1;
	logic         res_valid_s1;

	// Take a new request whenever the result register is empty or drains now.
	assign in_ready  = !res_valid_s1 || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Hold the conversion wait length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_len_q <= WAIT_RESET_VALUE;
		end else if (cfg_valid) begin
			wait_len_q <= cfg_data;
		end
	end

	// Advance the sequencer by one tick on each accepted request.
	owtsm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (in_fire),
		.tick     (in_data),
		.wait_len (wait_len_q),
		.status   (status),
		.id_next  (id_next),
		.raw_next (raw_next)
	);

	// Convert the updated raw temperature.
	owtsm_temp u_temp (
		.raw       (raw_next),
		.negative  (temp_neg),
		.magnitude (temp_mag)
	);

	// Result register: load on accept, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (in_fire) begin
			res_valid_s1 <= 1'b1;
		end else if (out_ready) begin
			res_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_s1.bus_pull_low   <= status.pull;
			res_s1.busy_res       <= status.busy;
			res_s1.done_res       <= status.done;
			res_s1.no_device      <= status.no_device;
			res_s1.rom_id         <= id_next;
			res_s1.temp_negative  <= temp_neg;
			res_s1.temp_magnitude <= temp_mag;
		end
	end

	assign out_valid = res_valid_s1;
	assign out_data  = res_s1;

	// A tick that finishes a sequence cannot also report a missing device.
	a_done_nodev_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.done_res && out_data.no_device))
		else $error("done and no_device set together");

	// Completion and abort ticks belong to a running sequence.
	a_flags_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.done_res || out_data.no_device) |-> out_data.busy_res)
		else $error("done or no_device outside a sequence");

	// The bus is released whenever no sequence runs.
	a_idle_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.busy_res |-> !out_data.bus_pull_low)
		else $error("bus driven while idle");

	// Every accepted request yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("result missing after accept");

endmodule
